// File: rtl/tge_pkg.sv
// shared constants, types and tables for the turtle graphics engine
// no dependencies
package tge_pkg;
    localparam int COORD_BITS = 24;
    localparam int STACK_DEPTH = 32;
    localparam int SP_BITS = $clog2(STACK_DEPTH);
    localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
    localparam int HEAD_BITS = 15;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_BITS = 5;
    localparam int CW = 34;
    localparam int ZW = 30;
    localparam logic [HEAD_BITS-1:0] FULL_TURN = 15'd23040;
    localparam logic [HEAD_BITS-1:0] QUARTER_TURN = 15'd5760;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [3:0] {
        ACT_FORWARD = 4'd0, ACT_LEFT = 4'd1, ACT_RIGHT = 4'd2, ACT_PUSH = 4'd3,
        ACT_POP = 4'd4, ACT_PEN_DOWN = 4'd5, ACT_PEN_UP = 4'd6,
        ACT_MOVE_TO = 4'd7, ACT_HOME = 4'd8
    } action_t;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_FULL = 2'd1;
    localparam logic [1:0] FAULT_EMPTY = 2'd2;

    typedef struct packed {
        logic start;
        logic [HEAD_BITS-1:0] heading;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        logic signed [CW-1:0] cs;
        logic signed [CW-1:0] sn;
    } cordic_rsp_t;

    function automatic logic signed [ZW-1:0] atan_lookup(input logic [STEP_BITS-1:0] i);
        case (i)
            5'd0: atan_lookup = 30'sd188743680;
            5'd1: atan_lookup = 30'sd111421905;
            5'd2: atan_lookup = 30'sd58872272;
            5'd3: atan_lookup = 30'sd29884485;
            5'd4: atan_lookup = 30'sd15000234;
            5'd5: atan_lookup = 30'sd7507429;
            5'd6: atan_lookup = 30'sd3754631;
            5'd7: atan_lookup = 30'sd1877430;
            5'd8: atan_lookup = 30'sd938729;
            5'd9: atan_lookup = 30'sd469366;
            5'd10: atan_lookup = 30'sd234683;
            5'd11: atan_lookup = 30'sd117342;
            5'd12: atan_lookup = 30'sd58671;
            5'd13: atan_lookup = 30'sd29335;
            5'd14: atan_lookup = 30'sd14668;
            5'd15: atan_lookup = 30'sd7334;
            5'd16: atan_lookup = 30'sd3667;
            5'd17: atan_lookup = 30'sd1833;
            5'd18: atan_lookup = 30'sd917;
            5'd19: atan_lookup = 30'sd458;
            5'd20: atan_lookup = 30'sd229;
            5'd21: atan_lookup = 30'sd115;
            5'd22: atan_lookup = 30'sd57;
            5'd23: atan_lookup = 30'sd29;
            default: atan_lookup = '0;
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [COORD_BITS+1:0] v);
        logic signed [COORD_BITS+1:0] hi;
        logic signed [COORD_BITS+1:0] lo;
        hi = (COORD_BITS+2)'((64'sd1 <<< (COORD_BITS - 1)) - 1);
        lo = -hi - (COORD_BITS+2)'(1);
        if (v > hi) sat_coord = hi[COORD_BITS-1:0];
        else if (v < lo) sat_coord = lo[COORD_BITS-1:0];
        else sat_coord = v[COORD_BITS-1:0];
    endfunction
endpackage

// File: rtl/tge_cordic.sv
// iterative cordic rotation unit, one micro-rotation per cycle
// depends on tge_pkg
module tge_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  tge_pkg::cordic_req_t req,
    output tge_pkg::cordic_rsp_t rsp
);
    logic signed [tge_pkg::CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [tge_pkg::ZW-1:0] z_reg, z_next;
    logic [tge_pkg::STEP_BITS-1:0] i_reg, i_next;
    logic [1:0] q_reg, q_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [tge_pkg::HEAD_BITS-1:0] rem;
    logic [1:0] quad;
    logic signed [tge_pkg::CW-1:0] xs, ys;

    always_comb begin
        quad = 2'd0;
        rem = req.heading;
        if (req.heading >= 3 * tge_pkg::QUARTER_TURN) begin
            quad = 2'd3;
            rem = req.heading - 15'(3 * tge_pkg::QUARTER_TURN);
        end else if (req.heading >= 2 * tge_pkg::QUARTER_TURN) begin
            quad = 2'd2;
            rem = req.heading - 15'(2 * tge_pkg::QUARTER_TURN);
        end else if (req.heading >= tge_pkg::QUARTER_TURN) begin
            quad = 2'd1;
            rem = req.heading - tge_pkg::QUARTER_TURN;
        end
    end

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; q_next = q_reg;
        busy_next = busy_reg; done_next = 1'b0;
        if (req.start) begin
            x_next = tge_pkg::CORDIC_GAIN;
            y_next = '0;
            z_next = $signed({1'b0, rem[12:0], 16'd0});
            i_next = '0;
            q_next = quad;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[tge_pkg::ZW-1]) begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - tge_pkg::atan_lookup(i_reg);
            end else begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + tge_pkg::atan_lookup(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(tge_pkg::CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        i_reg <= i_next; q_reg <= q_next;
    end

    always_comb begin
        rsp.done = done_reg;
        case (q_reg)
            2'd0: begin rsp.cs = x_reg; rsp.sn = y_reg; end
            2'd1: begin rsp.cs = -y_reg; rsp.sn = x_reg; end
            2'd2: begin rsp.cs = -x_reg; rsp.sn = -y_reg; end
            default: begin rsp.cs = y_reg; rsp.sn = -x_reg; end
        endcase
    end
endmodule

// File: rtl/turtle_graphics_engine_core.sv
// turtle graphics engine top level: sequencer, pose state, stack, box
// depends on tge_pkg and tge_cordic
// forward: decode, the 24 cordic steps, y and x multiply, box, add, box and output
// other commands: decode and output, with a restore step for a non-empty pop; one
// command at a time, a finished word is held in the output register and the next
// word is accepted the cycle after it is taken
// synchronous active-low reset: pose at origin facing 90 degrees, pen down,
// empty stack, box zero, line width 1
module turtle_graphics_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic signed [23:0] s_distance,
    input  logic signed [15:0] s_angle,
    input  logic signed [23:0] s_target_x,
    input  logic signed [23:0] s_target_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_drawn,
    output logic signed [23:0] m_start_x,
    output logic signed [23:0] m_start_y,
    output logic signed [23:0] m_end_x,
    output logic signed [23:0] m_end_y,
    output logic [14:0] m_heading,
    output logic signed [23:0] m_box_min_x,
    output logic signed [23:0] m_box_min_y,
    output logic signed [23:0] m_box_max_x,
    output logic signed [23:0] m_box_max_y,
    output logic [1:0]  m_stack_fault
);
    localparam int CB = tge_pkg::COORD_BITS;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001, ST_EXEC = 9'b000000010, ST_CORDIC = 9'b000000100,
        ST_MULX = 9'b000001000, ST_MULY = 9'b000010000, ST_ADD = 9'b000100000,
        ST_BOX = 9'b001000000, ST_POP = 9'b010000000, ST_OUT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] lw_reg;
    logic signed [CB-1:0] px_reg, py_reg, bx0_reg, by0_reg, bx1_reg, by1_reg;
    logic [14:0] hd_reg;
    logic pen_reg;
    logic [tge_pkg::CNT_BITS-1:0] cnt_reg;
    logic [3:0] act_reg;
    logic signed [23:0] dist_reg, tx_reg, ty_reg;
    logic signed [15:0] ang_reg;
    logic signed [CB-1:0] sx_reg, sy_reg;
    logic drawn_reg;
    logic [1:0] fault_reg;
    logic signed [63:0] prod_reg, prodx_reg;
    logic box_pass_reg;
    logic [62:0] mem [tge_pkg::STACK_DEPTH];
    logic [62:0] rd_reg;
    logic out_valid_reg;
    logic [tge_pkg::SP_BITS-1:0] top_idx;

    tge_pkg::cordic_req_t creq;
    tge_pkg::cordic_rsp_t crsp;

    tge_cordic u_cordic (.aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp));

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign creq.start = (state_reg == ST_EXEC) && (act_reg == tge_pkg::ACT_FORWARD);
    assign creq.heading = hd_reg;
    assign top_idx = tge_pkg::SP_BITS'(cnt_reg - 1'b1);

    // turn arithmetic
    logic signed [17:0] turn_sum;
    logic signed [17:0] turn_red;
    always_comb begin
        if (act_reg == tge_pkg::ACT_LEFT) turn_sum = $signed({3'b0, hd_reg}) + 18'(ang_reg);
        else turn_sum = $signed({3'b0, hd_reg}) - 18'(ang_reg);
        turn_red = turn_sum;
        if (turn_sum < -18'sd23040) turn_red = turn_sum + 18'sd46080;
        else if (turn_sum < 0) turn_red = turn_sum + 18'sd23040;
        else if (turn_sum >= 18'sd46080) turn_red = turn_sum - 18'sd46080;
        else if (turn_sum >= 18'sd23040) turn_red = turn_sum - 18'sd23040;
    end

    // box widening around the current position
    logic signed [CB+1:0] hw;
    logic signed [CB-1:0] wx0, wy0, wx1, wy1;
    always_comb begin
        hw = $signed({(CB+2-15)'(0), lw_reg[7:1], 8'd0});
        wx0 = tge_pkg::sat_coord((CB+2)'(px_reg) - hw);
        wy0 = tge_pkg::sat_coord((CB+2)'(py_reg) - hw);
        wx1 = tge_pkg::sat_coord((CB+2)'(px_reg) + hw);
        wy1 = tge_pkg::sat_coord((CB+2)'(py_reg) + hw);
    end

    logic signed [63:0] rnd_x, rnd_y;
    assign rnd_x = (prodx_reg + 64'sd536870912) >>> 30;
    assign rnd_y = (prod_reg + 64'sd536870912) >>> 30;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready) state_next = ST_EXEC;
            ST_EXEC: begin
                if (act_reg == tge_pkg::ACT_FORWARD) state_next = ST_CORDIC;
                else if (act_reg == tge_pkg::ACT_POP && cnt_reg != 0) state_next = ST_POP;
                else state_next = ST_OUT;
            end
            ST_CORDIC: if (crsp.done) state_next = ST_MULY;
            ST_MULY: state_next = ST_MULX;
            ST_MULX: state_next = ST_BOX;
            ST_BOX: state_next = box_pass_reg ? ST_OUT : ST_ADD;
            ST_ADD: state_next = ST_BOX;
            ST_POP: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lw_reg <= 8'd1;
            px_reg <= '0; py_reg <= '0;
            hd_reg <= tge_pkg::QUARTER_TURN;
            pen_reg <= 1'b1;
            cnt_reg <= '0;
            bx0_reg <= '0; by0_reg <= '0; bx1_reg <= '0; by1_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) lw_reg <= cfg_wdata;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    act_reg <= s_action; dist_reg <= s_distance; ang_reg <= s_angle;
                    tx_reg <= s_target_x; ty_reg <= s_target_y;
                    sx_reg <= px_reg; sy_reg <= py_reg;
                    drawn_reg <= 1'b0; fault_reg <= tge_pkg::FAULT_NONE;
                end
                ST_EXEC: begin
                    case (act_reg)
                        tge_pkg::ACT_FORWARD: drawn_reg <= pen_reg;
                        tge_pkg::ACT_LEFT, tge_pkg::ACT_RIGHT: hd_reg <= turn_red[14:0];
                        tge_pkg::ACT_PUSH: begin
                            if (cnt_reg >= tge_pkg::CNT_BITS'(tge_pkg::STACK_DEPTH))
                                fault_reg <= tge_pkg::FAULT_FULL;
                            else cnt_reg <= cnt_reg + 1'b1;
                        end
                        tge_pkg::ACT_POP: begin
                            if (cnt_reg == 0) fault_reg <= tge_pkg::FAULT_EMPTY;
                            else cnt_reg <= cnt_reg - 1'b1;
                        end
                        tge_pkg::ACT_PEN_DOWN: pen_reg <= 1'b1;
                        tge_pkg::ACT_PEN_UP: pen_reg <= 1'b0;
                        tge_pkg::ACT_MOVE_TO: begin px_reg <= tx_reg; py_reg <= ty_reg; end
                        tge_pkg::ACT_HOME: begin
                            px_reg <= '0; py_reg <= '0; hd_reg <= tge_pkg::QUARTER_TURN;
                        end
                        default: ;
                    endcase
                    box_pass_reg <= 1'b0;
                end
                ST_MULY: prod_reg <= 64'(dist_reg) * 64'(crsp.sn);
                ST_MULX: begin
                    prodx_reg <= 64'(dist_reg) * 64'(crsp.cs);
                end
                ST_BOX: begin
                    if (wx0 < bx0_reg) bx0_reg <= wx0;
                    if (wy0 < by0_reg) by0_reg <= wy0;
                    if (wx1 > bx1_reg) bx1_reg <= wx1;
                    if (wy1 > by1_reg) by1_reg <= wy1;
                    box_pass_reg <= 1'b1;
                end
                ST_ADD: begin
                    px_reg <= tge_pkg::sat_coord((CB+2)'(px_reg) + (CB+2)'(rnd_x));
                    py_reg <= tge_pkg::sat_coord((CB+2)'(py_reg) + (CB+2)'(rnd_y));
                end
                ST_POP: begin
                    px_reg <= rd_reg[62:39]; py_reg <= rd_reg[38:15]; hd_reg <= rd_reg[14:0];
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC && act_reg == tge_pkg::ACT_PUSH &&
            cnt_reg < tge_pkg::CNT_BITS'(tge_pkg::STACK_DEPTH))
            mem[cnt_reg[tge_pkg::SP_BITS-1:0]] <= {px_reg, py_reg, hd_reg};
        rd_reg <= mem[top_idx];
    end

    assign m_valid = out_valid_reg;
    assign m_drawn = drawn_reg;
    assign m_start_x = sx_reg;
    assign m_start_y = sy_reg;
    assign m_end_x = px_reg;
    assign m_end_y = py_reg;
    assign m_heading = hd_reg;
    assign m_box_min_x = bx0_reg;
    assign m_box_min_y = by0_reg;
    assign m_box_max_x = bx1_reg;
    assign m_box_max_y = by1_reg;
    assign m_stack_fault = fault_reg;
endmodule
